FILE: src/raster_edge_color_stats_core_macros.svh
// Assertion macros for the raster edge/color statistics checkers.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef RASTER_EDGE_COLOR_STATS_CORE_MACROS_SVH
`define RASTER_EDGE_COLOR_STATS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RECS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("recs checker: property violated");

// Consequent must hold in the cycle after the antecedent.
`define RECS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("recs checker: property violated");

`endif

FILE: src/recs_pkg.sv
// Shared types, constants and helper functions for the raster edge/color statistics core.
// Used by every RTL file of the block; depends on nothing else.
package recs_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CHAN_W     = 8;
    localparam int DIM_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PCOUNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W      = 32;
    localparam int EDGE_TOT_W = 35;
    localparam int DIFF_W     = CHAN_W + 2;
    localparam int PIX_EDGE_W = DIFF_W + 1;

    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = SUM_W + WEIGHT_W;
    localparam int LUM_W      = SUM_W + WEIGHT_W;
    localparam int LUM_FRAC   = 8;
    localparam int DENS_SHIFT = 7;
    localparam int DVD_W      = EDGE_TOT_W + DENS_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int DENS_W     = 18;
    localparam int AVG_W      = 16;

    // Rec.709 luma weights in Q16, rounded to nearest; they add up to 65536.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd4732;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [DENS_W-1:0]     edge_density_q8;
        logic [AVG_W-1:0]      average_luminance_q8;
        logic [SUM_W-1:0]      red_total;
        logic [SUM_W-1:0]      green_total;
        logic [SUM_W-1:0]      blue_total;
        logic [EDGE_TOT_W-1:0] edge_total;
    } stats_t;

    // Frame totals handed from the pixel path to the divider at the end of a frame.
    typedef struct packed {
        logic                  valid;
        logic [SUM_W-1:0]      red_total;
        logic [SUM_W-1:0]      green_total;
        logic [SUM_W-1:0]      blue_total;
        logic [EDGE_TOT_W-1:0] edge_total;
        logic [PCOUNT_W-1:0]   pixel_count;
    } frame_sums_t;

    // Clamp a dimension register to 1..maxv.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > maxv)
            r = DIM_W'(maxv);
        else
            r = v;
        return r;
    endfunction

    // Sum of the absolute per-channel differences of two pixels.
    function automatic logic [DIFF_W-1:0] pix_diff(input pixel_t a, input pixel_t b);
        logic [CHAN_W-1:0] dr;
        logic [CHAN_W-1:0] dg;
        logic [CHAN_W-1:0] db;
        dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
        dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
        db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
        return DIFF_W'(dr) + DIFF_W'(dg) + DIFF_W'(db);
    endfunction

endpackage

FILE: src/raster_edge_color_stats_core.sv
// Raster edge and color statistics core: one RGB pixel per beat in raster order; one result
// beat per frame with channel totals, edge total, Q8.8 average luminance and Q10.8 edge
// density. Pixels are taken at one per clock. The only exception is the pixel that closes a
// frame: it is held off (in_stall high) while the previous frame's end-of-frame unit is still
// busy. The end-of-frame unit does luminance weighting through one multiplier, then two
// 42-step shift-subtract divisions on a shared divider, then loads the output register. A
// result beat waits in the output register while out_stall is high; the next frame's result
// then waits in the end-of-frame unit, which stays busy. The upper neighbor comes from a
// single-port-read line buffer with a registered read; for one-pixel rows the value being
// written is forwarded. The line buffer is not cleared after reset and needs no clearing
// pass: the first row of a frame does not use what it reads. image_width and image_height
// are clamped to 1..4096 and must only be written while no frame is in progress.
module raster_edge_color_stats_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  recs_pkg::pixel_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output recs_pkg::stats_t                    out_data,
    input  logic                                cfg_write_enable,
    input  logic [recs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [recs_pkg::DIM_W-1:0]          cfg_data
);

    logic [recs_pkg::DIM_W-1:0] image_width_reg;
    logic [recs_pkg::DIM_W-1:0] image_height_reg;
    logic [recs_pkg::DIM_W-1:0] width_eff;
    logic [recs_pkg::DIM_W-1:0] height_eff;
    recs_pkg::frame_sums_t      sums;
    logic                       div_busy;

    // Configuration registers; a write takes effect on the next pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= recs_pkg::WIDTH_RESET;
            image_height_reg <= recs_pkg::HEIGHT_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (recs_pkg::cfg_reg_t'(cfg_index))
                recs_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                recs_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
            endcase
        end
    end

    // A zero dimension acts as one; anything above the line buffer size is clamped.
    assign width_eff  = recs_pkg::sat_dim(image_width_reg, recs_pkg::MAX_WIDTH);
    assign height_eff = recs_pkg::sat_dim(image_height_reg, recs_pkg::MAX_HEIGHT);

    // Pixel side: counters, line buffer, edge term and running sums.
    recs_pixel_path u_pixel_path (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .div_busy   (div_busy),
        .sums       (sums)
    );

    // Frame side: weighting, divisions and the result register.
    recs_frame_div u_frame_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .sums      (sums),
        .busy      (div_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: src/recs_line_buffer.sv
// Line buffer holding the previous row of pixels: one synchronous read port, one write port.
// Depends on recs_pkg for the pixel type and the maximum row length.
module recs_line_buffer (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [recs_pkg::COL_W-1:0] rd_addr,
    output recs_pkg::pixel_t         rd_data,
    input  logic                     wr_en,
    input  logic [recs_pkg::COL_W-1:0] wr_addr,
    input  recs_pkg::pixel_t         wr_data
);

    recs_pkg::pixel_t mem [recs_pkg::MAX_WIDTH];
    recs_pkg::pixel_t rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/recs_pixel_path.sv
// Per-pixel path: raster counters, line buffer access, edge term and running frame sums.
// Depends on recs_pkg and recs_line_buffer.
module recs_pixel_path (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  recs_pkg::pixel_t              in_data,
    output logic                          in_stall,
    input  logic [recs_pkg::DIM_W-1:0]    width_eff,
    input  logic [recs_pkg::DIM_W-1:0]    height_eff,
    input  logic                          div_busy,
    output recs_pkg::frame_sums_t         sums
);

    logic [recs_pkg::COL_W-1:0] col_reg;
    logic [recs_pkg::COL_W-1:0] col_next;
    logic [recs_pkg::ROW_W-1:0] row_reg;
    logic [recs_pkg::ROW_W-1:0] row_next;
    logic                       cur_row_end;
    logic                       cur_last;
    logic                       accept;

    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    recs_pkg::pixel_t           s1_pix_reg;
    logic [recs_pkg::COL_W-1:0] s1_col_reg;
    logic                       s1_has_left_reg;
    logic                       s1_has_up_reg;
    logic                       fwd_reg;
    recs_pkg::pixel_t           fwd_pix_reg;
    recs_pkg::pixel_t           left_reg;

    logic [recs_pkg::SUM_W-1:0]      red_acc_reg;
    logic [recs_pkg::SUM_W-1:0]      green_acc_reg;
    logic [recs_pkg::SUM_W-1:0]      blue_acc_reg;
    logic [recs_pkg::EDGE_TOT_W-1:0] edge_acc_reg;

    recs_pkg::pixel_t                rd_data;
    recs_pkg::pixel_t                up_pix;
    logic [recs_pkg::DIFF_W-1:0]     left_term;
    logic [recs_pkg::DIFF_W-1:0]     up_term;
    logic [recs_pkg::PIX_EDGE_W-1:0] pix_edge;
    logic [recs_pkg::SUM_W-1:0]      red_sum;
    logic [recs_pkg::SUM_W-1:0]      green_sum;
    logic [recs_pkg::SUM_W-1:0]      blue_sum;
    logic [recs_pkg::EDGE_TOT_W-1:0] edge_sum;

    assign cur_row_end = (recs_pkg::DIM_W'(col_reg) + recs_pkg::DIM_W'(1)) >= width_eff;
    assign cur_last    = cur_row_end &&
                         ((recs_pkg::DIM_W'(row_reg) + recs_pkg::DIM_W'(1)) >= height_eff);

    // A frame-closing pixel waits until the divider can take its totals.
    assign in_stall = cur_last && (div_busy || (s1_valid_reg && s1_last_reg));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (!cur_row_end)
            begin
                col_next = col_reg + recs_pkg::COL_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = cur_last ? '0 : row_reg + recs_pkg::ROW_W'(1);
            end
        end
    end

    recs_line_buffer u_line_buffer (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg)
    );

    // With a one-pixel row the upper neighbor is written in the same cycle it is read.
    assign up_pix    = fwd_reg ? fwd_pix_reg : rd_data;
    assign left_term = s1_has_left_reg ? recs_pkg::pix_diff(s1_pix_reg, left_reg) : '0;
    assign up_term   = s1_has_up_reg ? recs_pkg::pix_diff(s1_pix_reg, up_pix) : '0;
    assign pix_edge  = recs_pkg::PIX_EDGE_W'(left_term) + recs_pkg::PIX_EDGE_W'(up_term);

    assign red_sum   = red_acc_reg + recs_pkg::SUM_W'(s1_pix_reg.red);
    assign green_sum = green_acc_reg + recs_pkg::SUM_W'(s1_pix_reg.green);
    assign blue_sum  = blue_acc_reg + recs_pkg::SUM_W'(s1_pix_reg.blue);
    assign edge_sum  = edge_acc_reg + recs_pkg::EDGE_TOT_W'(pix_edge);

    assign sums.valid       = s1_valid_reg && s1_last_reg;
    assign sums.red_total   = red_sum;
    assign sums.green_total = green_sum;
    assign sums.blue_total  = blue_sum;
    assign sums.edge_total  = edge_sum;
    assign sums.pixel_count = recs_pkg::PCOUNT_W'(width_eff) * recs_pkg::PCOUNT_W'(height_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
            edge_acc_reg  <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_last_reg <= cur_last;
                fwd_reg     <= s1_valid_reg && (s1_col_reg == col_reg);
            end
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    red_acc_reg   <= '0;
                    green_acc_reg <= '0;
                    blue_acc_reg  <= '0;
                    edge_acc_reg  <= '0;
                end
                else
                begin
                    red_acc_reg   <= red_sum;
                    green_acc_reg <= green_sum;
                    blue_acc_reg  <= blue_sum;
                    edge_acc_reg  <= edge_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= in_data;
            s1_col_reg      <= col_reg;
            s1_has_left_reg <= (col_reg != '0);
            s1_has_up_reg   <= (row_reg != '0);
            fwd_pix_reg     <= s1_pix_reg;
        end
        if (s1_valid_reg)
        begin
            left_reg <= s1_pix_reg;
        end
    end

endmodule

FILE: src/recs_frame_div.sv
// End-of-frame unit: luminance weighting, two shift-subtract divisions and the result register.
// Depends on recs_pkg.
module recs_frame_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  recs_pkg::frame_sums_t sums,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output recs_pkg::stats_t      out_data
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_MUL      = 5'b00010,
        ST_DIV_EDGE = 5'b00100,
        ST_DIV_LUM  = 5'b01000,
        ST_DONE     = 5'b10000
    } div_state_t;

    localparam logic [1:0] MUL_LAST = 2'd3;

    div_state_t state_reg;
    div_state_t state_next;
    logic [1:0] step_reg;
    logic [recs_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic out_valid_reg;
    recs_pkg::stats_t out_data_reg;

    logic [recs_pkg::SUM_W-1:0]      red_reg;
    logic [recs_pkg::SUM_W-1:0]      green_reg;
    logic [recs_pkg::SUM_W-1:0]      blue_reg;
    logic [recs_pkg::EDGE_TOT_W-1:0] edge_reg;
    logic [recs_pkg::PCOUNT_W-1:0]   pcount_reg;
    logic [recs_pkg::PROD_W-1:0]     prod_reg;
    logic [recs_pkg::LUM_W-1:0]      lum_reg;
    logic [recs_pkg::DVD_W-1:0]      dvd_reg;
    logic [recs_pkg::PCOUNT_W-1:0]   rem_reg;
    logic [recs_pkg::DENS_W-1:0]     dens_reg;
    logic [recs_pkg::AVG_W-1:0]      avg_reg;

    logic [recs_pkg::SUM_W-1:0]      mul_src;
    logic [recs_pkg::WEIGHT_W-1:0]   mul_weight;
    logic [recs_pkg::PCOUNT_W:0]     trial;
    logic                            take;
    logic [recs_pkg::PCOUNT_W-1:0]   rem_step;
    logic [recs_pkg::DVD_W-1:0]      dvd_step;
    logic                            div_last;
    logic                            out_load;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                mul_src    = red_reg;
                mul_weight = recs_pkg::WEIGHT_RED;
            end
            2'd1:
            begin
                mul_src    = green_reg;
                mul_weight = recs_pkg::WEIGHT_GREEN;
            end
            default:
            begin
                mul_src    = blue_reg;
                mul_weight = recs_pkg::WEIGHT_BLUE;
            end
        endcase
    end

    // One restoring division step: one quotient bit per cycle.
    assign trial    = {rem_reg, dvd_reg[recs_pkg::DVD_W-1]};
    assign take     = trial >= {1'b0, pcount_reg};
    assign rem_step = take ? recs_pkg::PCOUNT_W'(trial - {1'b0, pcount_reg})
                           : recs_pkg::PCOUNT_W'(trial);
    assign dvd_step = {dvd_reg[recs_pkg::DVD_W-2:0], take};
    assign div_last = (cnt_reg == recs_pkg::DIV_CNT_W'(1));
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sums.valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == MUL_LAST)
                    state_next = ST_DIV_EDGE;
            end
            ST_DIV_EDGE:
            begin
                if (div_last)
                    state_next = ST_DIV_LUM;
            end
            ST_DIV_LUM:
            begin
                if (div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
                step_reg <= step_reg + 2'd1;
            else
                step_reg <= '0;
            if ((state_reg == ST_MUL) || (state_reg == ST_DIV_EDGE && div_last))
                cnt_reg <= recs_pkg::DIV_CNT_W'(recs_pkg::DVD_W);
            else if (state_reg == ST_DIV_EDGE || state_reg == ST_DIV_LUM)
                cnt_reg <= cnt_reg - recs_pkg::DIV_CNT_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sums.valid)
        begin
            red_reg    <= sums.red_total;
            green_reg  <= sums.green_total;
            blue_reg   <= sums.blue_total;
            edge_reg   <= sums.edge_total;
            pcount_reg <= sums.pixel_count;
            lum_reg    <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_src * mul_weight;
            if (step_reg != 2'd0)
                lum_reg <= lum_reg + prod_reg;
            if (step_reg == MUL_LAST)
            begin
                // Density is edge*256 / (2*P), taken as edge*128 / P.
                dvd_reg <= {edge_reg, {recs_pkg::DENS_SHIFT{1'b0}}};
                rem_reg <= '0;
            end
        end
        if (state_reg == ST_DIV_EDGE)
        begin
            if (div_last)
            begin
                dens_reg <= dvd_step[recs_pkg::DENS_W-1:0];
                dvd_reg  <= recs_pkg::DVD_W'(lum_reg[recs_pkg::LUM_W-1:recs_pkg::LUM_FRAC]);
                rem_reg  <= '0;
            end
            else
            begin
                dvd_reg <= dvd_step;
                rem_reg <= rem_step;
            end
        end
        if (state_reg == ST_DIV_LUM)
        begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
            if (div_last)
                avg_reg <= dvd_step[recs_pkg::AVG_W-1:0];
        end
        if (out_load)
        begin
            out_data_reg <= '{
                edge_density_q8:      dens_reg,
                average_luminance_q8: avg_reg,
                red_total:            red_reg,
                green_total:          green_reg,
                blue_total:           blue_reg,
                edge_total:           edge_reg
            };
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/recs_checker.sv
// Port-level checker for raster_edge_color_stats_core, attached by the bind at the end.
// Depends on recs_pkg and raster_edge_color_stats_core_macros.svh.
`include "raster_edge_color_stats_core_macros.svh"

module recs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input recs_pkg::stats_t out_data,
    input logic             cfg_write_enable
);

    // A result beat held by the receiver keeps its value.
    `RECS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Input stall only starts after a pixel was taken or a register was written.
    `RECS_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past((in_valid && !in_stall) || cfg_write_enable))

    // A frame without any edge energy has zero edge density.
    `RECS_ASSERT_NOW(a_flat_frame, out_valid && (out_data.edge_total == '0), out_data.edge_density_q8 == '0)

    // An all-black frame has zero average luminance.
    `RECS_ASSERT_NOW(a_black_frame, out_valid && (out_data.red_total == '0) && (out_data.green_total == '0) && (out_data.blue_total == '0), out_data.average_luminance_q8 == '0)

endmodule

bind raster_edge_color_stats_core recs_checker u_recs_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for raster_edge_color_stats_core: frames of RGB pixels go in, one
// statistics beat per frame comes out and is compared with a predictor kept in this file.
// Depends on recs_pkg for the beat types, the register indexes and the dimension limits.
`timescale 1ns / 100ps

module tb_top;
    import recs_pkg::*;

    // Rec.709 luma weights in Q16; the predictor keeps its own copy.
    localparam longint unsigned LUMA_W_RED   = 13933;
    localparam longint unsigned LUMA_W_GREEN = 46871;
    localparam longint unsigned LUMA_W_BLUE  = 4732;

    // Drain and tail hold-offs leave the end-of-frame unit time to finish, with margin.
    localparam int DRAIN_CYCLES  = 120;
    localparam int TAIL_CYCLES   = 250;
    localparam int RANDOM_PIXELS = 1450;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_CAP     = 40;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

    // One line of the directed stimulus: either a register write or a pixel beat. A pixel
    // that closes a frame may carry a hand-written result that replaces the predicted one.
    typedef struct {
        row_kind_t        kind;
        cfg_reg_t         reg_sel;
        logic [DIM_W-1:0] value;
        pixel_t           px;
        bit               typed;
        stats_t           want;
    } stim_row_t;

    logic             clk;
    logic             rst_n            = 1'b0;
    logic             in_valid         = 1'b0;
    logic             in_stall;
    pixel_t           in_data          = '0;
    logic             out_valid;
    logic             out_stall        = 1'b0;
    stats_t           out_data;
    logic             cfg_write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0] cfg_data         = '0;

    raster_edge_color_stats_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------------------------
    // Frame statistics predictor. It mirrors the block's architectural state: the two
    // dimension registers, the raster position, the left neighbor, the line buffer and the
    // four running sums. It is advanced once per accepted pixel beat.
    // ------------------------------------------------------------------------------------
    logic [DIM_W-1:0]      width_setting  = WIDTH_RESET;
    logic [DIM_W-1:0]      height_setting = HEIGHT_RESET;
    int unsigned           col_pos        = 0;
    int unsigned           row_pos        = 0;
    pixel_t                left_px        = '0;
    pixel_t                line_mem [MAX_WIDTH];
    logic [SUM_W-1:0]      sum_red        = '0;
    logic [SUM_W-1:0]      sum_green      = '0;
    logic [SUM_W-1:0]      sum_blue       = '0;
    logic [EDGE_TOT_W-1:0] sum_gradient   = '0;

    // Expected statistics beats, oldest first.
    stats_t      pending_stats[$];
    int unsigned mismatch_count = 0;
    int unsigned frames_seen    = 0;
    int unsigned burst_left     = 0;
    int unsigned cycle_count    = 0;

    // Zero acts as one; anything above the line buffer depth saturates.
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic int unsigned channel_gap(pixel_t a, pixel_t b);
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
        dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
        db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
        return dr + dg + db;
    endfunction

    // Folds one pixel into the frame sums. Returns 1 with the frame's statistics when the
    // pixel closes the frame, after which the sums and the raster position start over.
    function automatic bit absorb_pixel(input pixel_t px, output stats_t res);
        int unsigned     w;
        int unsigned     h;
        int unsigned     grad_inc;
        longint unsigned area;
        longint unsigned luma;
        w = clamp_dim(width_setting, MAX_WIDTH);
        h = clamp_dim(height_setting, MAX_HEIGHT);
        res = '0;
        sum_red   = sum_red + px.red;
        sum_green = sum_green + px.green;
        sum_blue  = sum_blue + px.blue;

        // Left neighbor only past the first column, upper neighbor only past the first row.
        grad_inc = 0;
        if (col_pos > 0)
            grad_inc += channel_gap(px, left_px);
        if (row_pos > 0)
            grad_inc += channel_gap(px, line_mem[col_pos]);
        sum_gradient = sum_gradient + grad_inc;
        left_px = px;
        line_mem[col_pos] = px;

        if (col_pos + 1 < w) begin
            col_pos++;
            return 1'b0;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return 1'b0;
        end

        area = longint'(w) * longint'(h);
        luma = longint'(sum_red) * LUMA_W_RED + longint'(sum_green) * LUMA_W_GREEN
             + longint'(sum_blue) * LUMA_W_BLUE;
        res.edge_density_q8      = DENS_W'((longint'(sum_gradient) << 8) / (area * 2));
        res.average_luminance_q8 = AVG_W'(luma / (area << 8));
        res.red_total            = sum_red;
        res.green_total          = sum_green;
        res.blue_total           = sum_blue;
        res.edge_total           = sum_gradient;
        row_pos      = 0;
        sum_red      = '0;
        sum_green    = '0;
        sum_blue     = '0;
        sum_gradient = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------------------
    // Directed stimulus rows.
    // ------------------------------------------------------------------------------------
    function automatic stim_row_t config_row(cfg_reg_t which, logic [DIM_W-1:0] val);
        stim_row_t row;
        row.kind    = ROW_CONFIG;
        row.reg_sel = which;
        row.value   = val;
        row.px      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic stim_row_t pixel_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        stim_row_t row;
        row.kind    = ROW_PIXEL;
        row.reg_sel = REG_IMAGE_WIDTH;
        row.value   = '0;
        row.px      = '{red: r, green: g, blue: b};
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              stats_t want);
        stim_row_t row;
        row       = pixel_row(r, g, b);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    // ------------------------------------------------------------------------------------
    // Pixel content: fully random, saturated channels, or a small step from the previous
    // pixel so that the edge sums cover quiet areas as well as hard edges.
    // ------------------------------------------------------------------------------------
    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 10)) - 5;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic pixel_t make_pixel(pixel_t near);
        pixel_t px;
        case ($urandom_range(0, 3))
            0, 1: px = 24'($urandom);
            2: begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
                px.red   = nudge(near.red);
                px.green = nudge(near.green);
                px.blue  = nudge(near.blue);
            end
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------------------
    // Mismatch reporting and result checking.
    // ------------------------------------------------------------------------------------
    task automatic log_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_stats(stats_t got);
        stats_t want;
        if (pending_stats.size() == 0) begin
            log_mismatch("statistics beat arrived with no frame pending");
            return;
        end
        want = pending_stats.pop_front();
        if (got.edge_density_q8 !== want.edge_density_q8)
            log_mismatch($sformatf("frame %0d edge_density_q8 got %0d want %0d", frames_seen,
                                   got.edge_density_q8, want.edge_density_q8));
        if (got.average_luminance_q8 !== want.average_luminance_q8)
            log_mismatch($sformatf("frame %0d average_luminance_q8 got %0d want %0d",
                                   frames_seen, got.average_luminance_q8,
                                   want.average_luminance_q8));
        if (got.red_total !== want.red_total)
            log_mismatch($sformatf("frame %0d red_total got %0d want %0d", frames_seen,
                                   got.red_total, want.red_total));
        if (got.green_total !== want.green_total)
            log_mismatch($sformatf("frame %0d green_total got %0d want %0d", frames_seen,
                                   got.green_total, want.green_total));
        if (got.blue_total !== want.blue_total)
            log_mismatch($sformatf("frame %0d blue_total got %0d want %0d", frames_seen,
                                   got.blue_total, want.blue_total));
        if (got.edge_total !== want.edge_total)
            log_mismatch($sformatf("frame %0d edge_total got %0d want %0d", frames_seen,
                                   got.edge_total, want.edge_total));
        frames_seen++;
    endtask

    // ------------------------------------------------------------------------------------
    // Pixel driver. Every task here starts and ends in the time step of a rising edge, so
    // the next beat or an idle is driven at that same edge and a beat is never repeated.
    // The handshake is observed on the falling edge, where in_stall has settled; a low
    // stall there means the beat is taken at the following rising edge.
    // ------------------------------------------------------------------------------------
    task automatic send_pixel(pixel_t px, bit typed, stats_t want);
        stats_t predicted;
        in_valid <= 1'b1;
        in_data  <= px;
        @(negedge clk);
        while (in_stall) begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        if (absorb_pixel(px, predicted))
            pending_stats.push_back(typed ? want : predicted);
    endtask

    // The sender works in bursts. Between bursts it usually leaves in_valid low; now and then a long
    // burst runs without any gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Register writes happen only between frames: every pending result must have come out,
    // and the end-of-frame unit gets its full latency to settle before the write.
    task automatic write_register(cfg_reg_t which, logic [DIM_W-1:0] val);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= which;
        cfg_data         <= val;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (which == REG_IMAGE_WIDTH)
            width_setting = val;
        else
            height_setting = val;
    endtask

    // Sets both dimensions and streams whole frames of generated pixels.
    task automatic run_frames(logic [DIM_W-1:0] w_val, logic [DIM_W-1:0] h_val,
                              int unsigned frames, output int unsigned px_count);
        int unsigned n;
        pixel_t      px;
        write_register(REG_IMAGE_WIDTH, w_val);
        write_register(REG_IMAGE_HEIGHT, h_val);
        n  = frames * clamp_dim(w_val, MAX_WIDTH) * clamp_dim(h_val, MAX_HEIGHT);
        px = '0;
        repeat (n) begin
            px = make_pixel(px);
            pace_sender();
            send_pixel(px, 1'b0, '0);
        end
        px_count = n;
    endtask

    // ------------------------------------------------------------------------------------
    // Clock, receiver stall pattern, result monitor and cycle limit.
    // ------------------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver stalls in segments, each with its own stall rate: from never up to
    // almost always, so result beats sit in the output register for varying times.
    initial begin : out_stall_pattern
        int unsigned seg_len;
        int unsigned duty;
        forever begin
            seg_len = $urandom_range(10, 300);
            case ($urandom_range(0, 3))
                0:       duty = 0;
                1:       duty = 30;
                2:       duty = 60;
                default: duty = 95;
            endcase
            repeat (seg_len) begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    // A result beat is taken at the rising edge after a falling edge that shows valid high
    // and stall low; the payload is stable over that half cycle.
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall)
            compare_stats(out_data);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames pending", cycle_count,
                     pending_stats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence: reset, directed rows, two full-size frames, then random phases.
    // ------------------------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t        stim_rows[$];
        int unsigned      random_pixels;
        int unsigned      n;
        int unsigned      sel;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;

        // Directed part. One-pixel frames with zero dimensions (both act as one), each
        // channel at its extremes, a two-pixel row and a two-pixel column (the latter
        // takes the upper neighbor from the pixel just written), then small frames with
        // mixed bit patterns checked by the predictor.
        stim_rows = '{
            config_row(REG_IMAGE_WIDTH, 13'd0),
            config_row(REG_IMAGE_HEIGHT, 13'd0),
            checked_row(8'hFF, 8'hFF, 8'hFF,
                        '{18'd0, 16'd65280, 32'd255, 32'd255, 32'd255, 35'd0}),
            checked_row(8'h00, 8'h00, 8'h00, '{18'd0, 16'd0, 32'd0, 32'd0, 32'd0, 35'd0}),
            pixel_row(8'hFF, 8'h00, 8'h00),
            pixel_row(8'h00, 8'hFF, 8'h00),
            pixel_row(8'h00, 8'h00, 8'hFF),
            config_row(REG_IMAGE_WIDTH, 13'd2),
            config_row(REG_IMAGE_HEIGHT, 13'd1),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            checked_row(8'h00, 8'h00, 8'h00,
                        '{18'd48960, 16'd32640, 32'd255, 32'd255, 32'd255, 35'd765}),
            config_row(REG_IMAGE_WIDTH, 13'd1),
            config_row(REG_IMAGE_HEIGHT, 13'd2),
            pixel_row(8'h00, 8'h00, 8'h00),
            checked_row(8'hFF, 8'hFF, 8'hFF,
                        '{18'd48960, 16'd32640, 32'd255, 32'd255, 32'd255, 35'd765}),
            config_row(REG_IMAGE_WIDTH, 13'd3),
            config_row(REG_IMAGE_HEIGHT, 13'd3),
            pixel_row(8'hAA, 8'h55, 8'h0F),
            pixel_row(8'h55, 8'hAA, 8'hF0),
            pixel_row(8'h01, 8'h80, 8'hFE),
            pixel_row(8'hFF, 8'h00, 8'h7F),
            pixel_row(8'h10, 8'h20, 8'h30),
            pixel_row(8'h80, 8'h80, 8'h80),
            pixel_row(8'h00, 8'hFF, 8'h01),
            pixel_row(8'h7E, 8'h81, 8'hC3),
            pixel_row(8'hFE, 8'h02, 8'h40),
            config_row(REG_IMAGE_WIDTH, 13'd2),
            config_row(REG_IMAGE_HEIGHT, 13'd2),
            pixel_row(8'h01, 8'h02, 8'h03),
            pixel_row(8'hFE, 8'hFD, 8'hFC),
            pixel_row(8'h80, 8'h7F, 8'h81),
            pixel_row(8'h00, 8'hFF, 8'h00)
        };

        // Reset is held low from time zero and released at a rising edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CONFIG)
                write_register(stim_rows[i].reg_sel, stim_rows[i].value);
            else begin
                pace_sender();
                send_pixel(stim_rows[i].px, stim_rows[i].typed, stim_rows[i].want);
            end
        end

        // Full-size frames: a single row with the width register at all ones (saturates
        // to the line buffer depth) and a single column with the height at all ones.
        run_frames(13'h1FFF, 13'd0, 1, n);
        run_frames(13'd0, 13'h1FFF, 1, n);

        // Random phases, mostly small frames so that many results come out. Now and then
        // a long single row exercises the wider width bits; those pixels are not counted.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                w_val = $urandom_range(65, 1023);
                h_val = $urandom_range(0, 1);
                run_frames(w_val, h_val, 1, n);
            end
            else begin
                w_val = (sel == 1) ? 13'd0 : 13'($urandom_range(1, 12));
                h_val = (sel == 2) ? 13'd0 : 13'($urandom_range(1, 6));
                if (sel == 3) begin
                    w_val = $urandom_range(13, 40);
                    h_val = $urandom_range(1, 2);
                end
                run_frames(w_val, h_val, $urandom_range(1, 4), n);
                random_pixels += n;
            end
        end

        // Drain: every frame's statistics must come out, then a quiet tail catches any
        // stray beat.
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
